@@ design/bfq_pkg.sv @@
package bfq_pkg;

    localparam int ArrayWords = 65536;
    localparam int AddrW      = 16;
    localparam int MaxProbes  = 32;
    localparam int FbW        = 23;
    localparam int HcW        = 6;

    localparam logic [31:0] C1      = 32'hcc9e2d51;
    localparam logic [31:0] C2      = 32'h1b873593;
    localparam logic [31:0] CN      = 32'he6546b64;
    localparam logic [31:0] F1      = 32'h85ebca6b;
    localparam logic [31:0] F2      = 32'hc2b2ae35;
    localparam logic [31:0] SeedStp = 32'h9e3779b9;
    localparam logic [31:0] KeyLen  = 32'd20;

    localparam logic CmdWrite = 1'b0;
    localparam logic CmdQuery = 1'b1;

    localparam logic [0:0] RegFilterBits = 1'b0;
    localparam logic [0:0] RegHashCount  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load_key;   // capture key, clear seed
        logic hash_start; // begin hashing current seed
        logic mem_write;  // store word
        logic next_seed;  // advance seed
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hash_done;  // bit index ready, memory read issued
        logic rd_valid;   // tested bit available
        logic bit_value;
    } t_stat;

endpackage

@@ design/bfq_datapath.sv @@
module bfq_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bfq_pkg::t_cmd              i_cmd,
    output bfq_pkg::t_stat             o_stat,
    input  logic [bfq_pkg::FbW-1:0]    i_divisor,
    input  logic [15:0]                i_word_index,
    input  logic [63:0]                i_word_data,
    input  logic [159:0]               i_key
);
    // phases of the hash unit
    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_K1   = 4'd1;
    localparam logic [3:0] PH_K2   = 4'd2;
    localparam logic [3:0] PH_H    = 4'd3;
    localparam logic [3:0] PH_F1   = 4'd4;
    localparam logic [3:0] PH_F2   = 4'd5;
    localparam logic [3:0] PH_F3   = 4'd6;
    localparam logic [3:0] PH_MOD  = 4'd7;
    localparam logic [3:0] PH_RD   = 4'd8;

    logic [63:0] r_mem [bfq_pkg::ArrayWords];

    logic [3:0]   r_ph;
    logic [159:0] r_blocks;
    logic [31:0]  r_seed, r_h, r_k;
    logic [2:0]   r_blk;
    logic [54:0]  r_rem;      // shifting remainder/dividend
    logic [4:0]   r_mcnt;
    logic [63:0]  r_rdata;
    logic [5:0]   r_bitsel;
    logic         r_rvalid, r_oob;
    logic [31:0]  blk, hx;
    logic [23:0]  trial;
    logic [22:0]  rem_cur;

    // current block, byte swapped; final hash mix, remainder and trial subtraction
    always_comb begin
        blk = r_blocks[31:0];
        blk = {blk[7:0], blk[15:8], blk[23:16], blk[31:24]};
        hx  = r_h ^ (r_h >> 16);
        rem_cur = r_rem[54:32];
        trial = {rem_cur, r_rem[31]} - {1'b0, i_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph     <= PH_IDLE;
            r_rvalid <= 1'b0;
        end else begin
            r_rvalid <= (r_ph == PH_RD);
            case (r_ph)
                PH_IDLE: begin
                    // key is captured while the unit is idle
                    if (i_cmd.load_key) begin
                        r_blocks <= i_key;
                    end
                    if (i_cmd.hash_start) begin
                        r_ph  <= PH_K1;
                        r_h   <= r_seed;
                        r_blk <= 3'd0;
                    end
                end
                PH_K1: begin
                    r_k  <= blk * bfq_pkg::C1;
                    r_ph <= PH_K2;
                end
                PH_K2: begin
                    r_k  <= {r_k[16:0], r_k[31:17]} * bfq_pkg::C2;
                    r_ph <= PH_H;
                end
                PH_H: begin
                    r_h      <= ({r_h[18:0] ^ r_k[18:0], (r_h[31:19] ^ r_k[31:19])} * 32'd5)
                                + bfq_pkg::CN;
                    r_blocks <= {r_blocks[31:0], r_blocks[159:32]};
                    r_blk    <= r_blk + 3'd1;
                    if (r_blk == 3'd4) begin
                        r_ph <= PH_F1;
                    end else begin
                        r_ph <= PH_K1;
                    end
                end
                PH_F1: begin
                    r_h  <= ((r_h ^ bfq_pkg::KeyLen) ^ ((r_h ^ bfq_pkg::KeyLen) >> 16))
                            * bfq_pkg::F1;
                    r_ph <= PH_F2;
                end
                PH_F2: begin
                    r_h  <= (r_h ^ (r_h >> 13)) * bfq_pkg::F2;
                    r_ph <= PH_F3;
                end
                PH_F3: begin
                    // restoring divide, one quotient bit per cycle
                    r_rem  <= {23'd0, hx};
                    r_mcnt <= 5'd0;
                    r_ph   <= PH_MOD;
                end
                PH_MOD: begin
                    if (!trial[23]) begin
                        r_rem <= {trial[22:0], r_rem[30:0], 1'b0};
                    end else begin
                        r_rem <= {r_rem[53:0], 1'b0};
                    end
                    r_mcnt <= r_mcnt + 5'd1;
                    if (r_mcnt == 5'd31) begin
                        r_ph <= PH_RD;
                    end
                end
                PH_RD: begin
                    r_ph <= PH_IDLE;
                end
                default: r_ph <= PH_IDLE;
            endcase
        end
    end

    // seed register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_key) begin
            r_seed <= 32'd0;
        end else if (i_cmd.next_seed) begin
            r_seed <= r_seed + bfq_pkg::SeedStp;
        end
    end

    // bit array: one write or one read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_write) begin
            r_mem[i_word_index] <= i_word_data;
        end
        if (r_ph == PH_RD) begin
            r_rdata  <= r_mem[rem_cur[bfq_pkg::AddrW+5:6]];
            r_bitsel <= rem_cur[5:0];
            r_oob    <= rem_cur[22];
        end
    end

    assign o_stat.hash_done = (r_ph == PH_RD);
    assign o_stat.rd_valid  = r_rvalid;
    assign o_stat.bit_value = !r_oob && r_rdata[r_bitsel];

`ifndef SYNTHESIS
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == PH_RD) |-> (rem_cur < i_divisor))
        else $error("remainder not below divisor");
    a_rd_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == PH_RD) |=> r_rvalid)
        else $error("read data missing");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hash_start |-> (r_ph == PH_IDLE))
        else $error("hash start while busy");
`endif

endmodule

@@ design/bfq_ctrl.sv @@
module bfq_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_command,
    input  logic [bfq_pkg::HcW-1:0]    i_hash_count,
    output bfq_pkg::t_cmd              o_cmd,
    input  bfq_pkg::t_stat             i_stat,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_present,
    output logic [5:0]                 o_used
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_HASH = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state, n_state;
    logic [5:0] r_used, r_limit;
    logic       r_present;
    logic       accept;
    logic [5:0] lim;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    always_comb begin
        lim = i_hash_count;
        if (lim == 6'd0) lim = 6'd1;
        if (lim > 6'(bfq_pkg::MaxProbes)) lim = 6'(bfq_pkg::MaxProbes);
    end

    always_comb begin
        o_cmd.load_key   = accept && (i_command == bfq_pkg::CmdQuery);
        o_cmd.mem_write  = accept && (i_command == bfq_pkg::CmdWrite);
        o_cmd.hash_start = (r_state == S_HASH);
        o_cmd.next_seed  = i_stat.hash_done;
        n_state = r_state;
        case (r_state)
            S_IDLE: if (o_cmd.load_key) n_state = S_HASH;
            S_HASH: n_state = S_WAIT;
            S_WAIT: begin
                if (i_stat.rd_valid) begin
                    if (!i_stat.bit_value || r_used == r_limit) n_state = S_OUT;
                    else n_state = S_HASH;
                end
            end
            S_OUT:  if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (o_cmd.load_key) begin
            r_used  <= 6'd0;
            r_limit <= lim;
        end else if (r_state == S_HASH) begin
            r_used <= r_used + 6'd1;
        end
        if (r_state == S_WAIT && i_stat.rd_valid) begin
            r_present <= i_stat.bit_value;
        end
    end

    assign o_out_valid = (r_state == S_OUT);
    assign o_present   = r_present;
    assign o_used      = r_used;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_used >= 6'd1 && r_used <= r_limit))
        else $error("probe count out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(r_used)))
        else $error("result changed while stalled");
    a_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_used != r_limit) |-> !r_present)
        else $error("early stop without clear bit");
`endif

endmodule

@@ design/bloom_filter_query.sv @@
// channel  | dir | handshake                | payload
// cfg      | in  | i_cfg_valid/o_cfg_ready  | i_cfg_index, i_cfg_data
// s_axis   | in  | tvalid/tready            | tuser=command, tdata=index,data,key
// m_axis   | out | tvalid/tready            | tdata=maybe_present,probes_used
// A write is stored when it is accepted. A query runs, per probe, an issue step,
// five blocks of three multiply steps, three finalization steps, a bit-serial
// modulo, one memory read and one decision step, then holds its result
// on the output until it is taken.
// Reset is synchronous active low; the bit array is not cleared.
// Input is stalled from query acceptance until its result is taken.
module bloom_filter_query (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [22:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic         s_axis_tuser,   // command
    // word_index[15:0], word_data[79:16], key_word0..4 [239:80]
    input  logic [239:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // maybe_present[0], probes_used[6:1], zero fill [7]
    output logic [7:0]   m_axis_tdata
);
    logic [bfq_pkg::FbW-1:0] r_filter_bits, divisor;
    logic [bfq_pkg::HcW-1:0] r_hash_count;
    bfq_pkg::t_cmd  cmd;
    bfq_pkg::t_stat stat;
    logic           present;
    logic [5:0]     used;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_bits <= 23'd4194304;
            r_hash_count  <= 6'd7;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bfq_pkg::RegFilterBits: r_filter_bits <= i_cfg_data;
                bfq_pkg::RegHashCount:  r_hash_count  <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    assign divisor = (r_filter_bits == '0) ? 23'd1 : r_filter_bits;

    bfq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_command    (s_axis_tuser),
        .i_hash_count (r_hash_count),
        .o_cmd        (cmd),
        .i_stat       (stat),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_present    (present),
        .o_used       (used)
    );

    bfq_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_divisor    (divisor),
        .i_word_index (s_axis_tdata[15:0]),
        .i_word_data  (s_axis_tdata[79:16]),
        .i_key        (s_axis_tdata[239:80])
    );

    assign m_axis_tdata = {1'b0, used, present};

endmodule

@@ tb/bloom_filter_query_tb.sv @@
`timescale 1ns / 100ps

module bloom_filter_query_tb;

    localparam int LimitCycles = 12000000;

    typedef struct {
        bit       present;
        bit [5:0] used;
    } t_answer;

    // Membership predictor and answer checker
    class bloom_scoreboard;
        bit [63:0]   words[int];
        bit [22:0]   fbits;
        bit [5:0]    hcount;
        t_answer     answers[$];
        int          errors;

        function void reset_regs();
            fbits  = 23'd4194304;
            hcount = 6'd7;
        endfunction

        function void set_reg(bit idx, bit [22:0] val);
            if (idx == bfq_pkg::RegFilterBits)
                fbits = val;
            else
                hcount = val[5:0];
        endfunction

        function bit [31:0] murmur(bit [31:0] blk[5], bit [31:0] seed);
            bit [31:0] h;
            bit [31:0] k;
            h = seed;
            for (int i = 0; i < 5; i++) begin
                k = blk[i] * 32'hcc9e2d51;
                k = {k[16:0], k[31:17]};
                k = k * 32'h1b873593;
                h = h ^ k;
                h = {h[18:0], h[31:19]};
                h = h * 32'd5 + 32'he6546b64;
            end
            h = h ^ 32'd20;
            h = h ^ (h >> 16);
            h = h * 32'h85ebca6b;
            h = h ^ (h >> 13);
            h = h * 32'hc2b2ae35;
            h = h ^ (h >> 16);
            return h;
        endfunction

        // Returns 0 when the query would read a word never loaded
        function bit lookup(bit [159:0] key, output bit present, output bit [5:0] used);
            bit [31:0] blk[5];
            bit [31:0] w;
            bit [31:0] div;
            bit [31:0] h;
            int        probes;
            for (int i = 0; i < 5; i++) begin
                w = key[32*i +: 32];
                blk[i] = {w[7:0], w[15:8], w[23:16], w[31:24]};
            end
            div    = (fbits == 0) ? 32'd1 : {9'd0, fbits};
            probes = (hcount == 0) ? 1 :
                     (hcount > bfq_pkg::MaxProbes ? bfq_pkg::MaxProbes : hcount);
            present = 1'b1;
            used    = 0;
            for (int i = 0; i < probes; i++) begin
                h = murmur(blk, i * bfq_pkg::SeedStp) % div;
                used++;
                if (!words.exists(int'(h >> 6)))
                    return 1'b0;
                if (!words[int'(h >> 6)][h[5:0]]) begin
                    present = 1'b0;
                    break;
                end
            end
            return 1'b1;
        endfunction

        function void note_item(bit cmd, bit [239:0] d);
            t_answer a;
            if (cmd == bfq_pkg::CmdWrite) begin
                words[int'(d[15:0])] = d[79:16];
            end else begin
                void'(lookup(d[239:80], a.present, a.used));
                answers.push_back(a);
            end
        endfunction

        function void check_result(bit [7:0] d);
            t_answer a;
            if (answers.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: tdata=%h", d);
                return;
            end
            a = answers.pop_front();
            if (d[0] !== a.present || d[6:1] !== a.used || d[7] !== 1'b0) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: present exp %0d got %0d, probes exp %0d got %0d",
                             a.present, d[0], a.used, d[6:1]);
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic         i_cfg_index;
    logic [22:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic         s_axis_tuser;
    logic [239:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [7:0]   m_axis_tdata;

    bloom_scoreboard sb;
    bit              quiet;
    int              cycles;

    bloom_filter_query dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: random stalls, check on every accepted item
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready = quiet || ($urandom_range(99) >= 37);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LimitCycles) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    task automatic send(bit cmd, bit [239:0] d);
        while (!quiet && $urandom_range(99) < 37)
            @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = d;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.note_item(cmd, d);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic load_word(bit [15:0] idx, bit [63:0] data);
        send(bfq_pkg::CmdWrite, {160'd0, data, idx});
    endtask

    // Key with extreme or random words
    function automatic bit [159:0] rand_key();
        bit [159:0] k;
        for (int i = 0; i < 5; i++)
            case ($urandom_range(5))
                0:       k[32*i +: 32] = 32'd0;
                1:       k[32*i +: 32] = 32'hffffffff;
                default: k[32*i +: 32] = $urandom;
            endcase
        return k;
    endfunction

    // Query a key only if it reads loaded words; search otherwise
    task automatic query(bit [159:0] key);
        bit       p;
        bit [5:0] u;
        int       tries;
        tries = 0;
        while (!sb.lookup(key, p, u) && tries < 4000) begin
            key = rand_key();
            tries++;
        end
        if (tries < 4000)
            send(bfq_pkg::CmdQuery, {key, 80'd0});
    endtask

    function automatic bit [63:0] dense_data();
        case ($urandom_range(3))
            0:       return {$urandom, $urandom};
            1:       return 64'hffffffffffffffff;
            default: return {$urandom, $urandom} | {$urandom, $urandom} |
                            {$urandom, $urandom} | {$urandom, $urandom};
        endcase
    endfunction

    task automatic drain();
        while (sb.answers.size() != 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(bit idx, bit [22:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic configure(bit [22:0] fb, bit [5:0] hc);
        drain();
        write_reg(bfq_pkg::RegFilterBits, fb);
        write_reg(bfq_pkg::RegHashCount, hc);
    endtask

    initial begin
        bit [22:0] fb_list[8];
        bit [5:0]  hc_list[8];
        bit [22:0] fb;
        bit [5:0]  hc;

        fb_list = '{23'd1, 23'd64, 23'd700, 23'd32768,
                    23'd4194304, 23'd4194304, 23'd0, 23'd4194303};
        hc_list = '{6'd1, 6'd32, 6'd3, 6'd7, 6'd7, 6'd5, 6'd0, 6'd20};
        sb = new();
        sb.reset_regs();
        quiet         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = 1'b0;
        s_axis_tdata  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extreme words and keys, zero divisor, zero and oversized probe count
        load_word(16'd0, 64'd0);
        load_word(16'hffff, 64'hffffffffffffffff);
        query({160{1'b1}});
        configure(23'd0, 6'd0);
        query(160'd0);
        query({160{1'b1}});
        load_word(16'd0, 64'd1);
        query(160'd0);
        query({5{32'haaaa5555}});
        configure(23'd1, 6'd63);
        query({160{1'b1}});
        query({5{32'h5555aaaa}});
        load_word(16'd0, 64'hfffffffffffffffe);
        query(160'd0);

        // Load the low words so small filters never read unloaded state
        for (int i = 0; i < 512; i++)
            load_word(i[15:0], dense_data());

        // Random phases over several settings
        for (int ph = 0; ph < 8; ph++) begin
            fb = fb_list[ph];
            hc = hc_list[ph];
            if (ph == 6) begin
                fb = $urandom_range(32768, 1);
                hc = $urandom_range(12, 1);
            end
            configure(fb, hc);
            quiet = (ph == 2);
            for (int n = 0; n < 160; n++) begin
                if ($urandom_range(99) < 25) begin
                    if ($urandom_range(1))
                        load_word($urandom_range(511), dense_data());
                    else
                        load_word($urandom, dense_data());
                end else begin
                    query(rand_key());
                end
            end
        end
        quiet = 1'b0;

        drain();
        repeat (1500) @(negedge i_clk);
        if (sb.errors == 0 && sb.answers.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
